// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the top level of the sorted value table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SVT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/svt_pkg.sv -----
// shared constants, codes and controller/datapath structs of the sorted value table
package svt_pkg;

  // default table depth
  localparam int unsigned SVT_CAPACITY = 64;

  // payload field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // min and max reported for an empty table
  localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

  // operation codes of an input item
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // working index update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_FILL,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  // memory read address select
  typedef enum logic [2:0] {
    RD_NONE,
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_FIRST,
    RD_LAST
  } rd_sel_e;

  // memory write data select, always written at the working index
  typedef enum logic [1:0] {
    WR_NONE,
    WR_VALUE,
    WR_RDATA
  } wr_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    capture;
    idx_op_e idx_op;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    fill_inc;
    logic    fill_dec;
    logic    set_hit;
    logic    set_miss;
    logic    set_full;
    logic    cap_lo;
    logic    cap_hi;
    logic    load_out;
  } svt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             full;
    logic             idx_zero;
    logic             idx_at_fill;
    logic             idx_last;
    logic             rd_gt;
    logic             rd_eq;
    logic             out_busy;
  } svt_stat_t;

endpackage

// ----- rtl/core/svt_if.sv -----
// request and response channel interfaces of the sorted value table

// request channel: operation and operand
interface svt_req_if import svt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

// response channel: one result item per request
interface svt_rsp_if import svt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        entry_count;
  logic signed [VALUE_W-1:0] smallest;
  logic signed [VALUE_W-1:0] largest;
  logic                      is_empty;

  modport source (
    output valid, output hit, output status, output entry_count,
    output smallest, output largest, output is_empty, input ready
  );
  modport sink (
    input valid, input hit, input status, input entry_count,
    input smallest, input largest, input is_empty, output ready
  );
endinterface

// ----- rtl/core/sorted_value_table.sv -----
// top level of the sorted value table: controller, datapath and assertions
//
// Keeps up to CAPACITY signed 32-bit values in ascending order (duplicates kept,
// a new value goes after equal ones) in a single-port-read, single-port-write
// memory, with one request at a time. Insert walks down from the top, moving
// each larger entry up one place; delete scans up to the first match and then
// moves the later entries down; search scans up to the first match or the
// first larger entry. Every memory step is a registered read followed by a
// compare or write, and every operation ends by reading the first and last
// entry for the min and max before the result goes to the output register.
// A new request is taken while the previous result still waits in the
// output register. No clearing pass after reset.
`include "assert_macros.svh"

module sorted_value_table import svt_pkg::*; #(
  parameter int unsigned CAPACITY = SVT_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  svt_req_if.sink   req_i,
  svt_rsp_if.source rsp_o
);

  svt_cmd_t  dp_cmd;
  svt_stat_t dp_stat;
  logic      req_ready;

  assign req_i.ready = req_ready;

  // operation sequencer
  svt_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // storage and result path
  svt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .req_cmd_i         (req_i.cmd),
    .req_value_i       (req_i.value),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_hit_o         (rsp_o.hit),
    .rsp_status_o      (rsp_o.status),
    .rsp_entry_count_o (rsp_o.entry_count),
    .rsp_smallest_o    (rsp_o.smallest),
    .rsp_largest_o     (rsp_o.largest),
    .rsp_is_empty_o    (rsp_o.is_empty)
  );

  // a full table never grows
  `SVT_ASSERT_IMPL(a_full_no_grow, clk_i, rst_ni, dp_stat.full, !dp_cmd.fill_inc, "full table grew")

  // one item at a time: busy right after an accept
  `SVT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready, "request taken while busy")

  // a hit always reports ok status
  `SVT_ASSERT_IMPL(a_hit_ok, clk_i, rst_ni, rsp_o.valid && rsp_o.hit, rsp_o.status == ST_OK, "hit with error status")

  // an empty table reports a zero count
  `SVT_ASSERT_IMPL(a_empty_count, clk_i, rst_ni, rsp_o.valid && rsp_o.is_empty, rsp_o.entry_count == '0, "empty with nonzero count")

endmodule

// ----- rtl/core/svt_ram.sv -----
// generic single write port, single read port ram with registered read data
module svt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/svt_datapath.sv -----
// datapath of the sorted value table: entry memory, index, fill level and result register
module svt_datapath import svt_pkg::*; #(
  parameter int unsigned CAPACITY = SVT_CAPACITY
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  svt_cmd_t                  cmd_i,
  output svt_stat_t                 stat_o,
  input  logic [CMD_W-1:0]          req_cmd_i,
  input  logic signed [VALUE_W-1:0] req_value_i,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output logic                      rsp_hit_o,
  output logic [STATUS_W-1:0]       rsp_status_o,
  output logic [COUNT_W-1:0]        rsp_entry_count_o,
  output logic signed [VALUE_W-1:0] rsp_smallest_o,
  output logic signed [VALUE_W-1:0] rsp_largest_o,
  output logic                      rsp_is_empty_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // operation context
  logic [CMD_W-1:0]          op_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                      hit_q;
  status_e                   status_q;

  // index and fill level
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] idx_m1, idx_p1, fill_m1;

  // captured extremes
  logic [VALUE_W-1:0] lo_q, hi_q;

  // memory port signals
  logic               ram_we;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [CW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // result register
  logic                      rsp_valid_q;
  logic                      rsp_hit_q;
  logic [STATUS_W-1:0]       rsp_status_q;
  logic [COUNT_W-1:0]        rsp_count_q;
  logic [VALUE_W-1:0]        rsp_smallest_q;
  logic [VALUE_W-1:0]        rsp_largest_q;
  logic                      rsp_empty_q;
  logic                      fill_empty;
  logic [CW+COUNT_W-1:0]     fill_ext;

  assign idx_m1     = idx_q - CW'(1);
  assign idx_p1     = idx_q + CW'(1);
  assign fill_m1    = fill_q - CW'(1);
  assign fill_empty = (fill_q == '0);
  assign fill_ext   = {{COUNT_W{1'b0}}, fill_q};

  // read address select
  always_comb begin
    ram_re    = 1'b1;
    ram_raddr = idx_q;
    unique case (cmd_i.rd_sel)
      RD_IDX:    ram_raddr = idx_q;
      RD_IDX_M1: ram_raddr = idx_m1;
      RD_IDX_P1: ram_raddr = idx_p1;
      RD_FIRST:  ram_raddr = '0;
      RD_LAST:   ram_raddr = fill_m1;
      default:   ram_re    = 1'b0;
    endcase
  end

  // write data select, address is the working index
  always_comb begin
    ram_we    = 1'b1;
    ram_wdata = value_q;
    unique case (cmd_i.wr_sel)
      WR_VALUE: ram_wdata = value_q;
      WR_RDATA: ram_wdata = ram_rdata;
      default:  ram_we    = 1'b0;
    endcase
  end

  svt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // index and fill level next values
  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_ZERO: idx_d = '0;
      IDX_FILL: idx_d = fill_q;
      IDX_INC:  idx_d = idx_p1;
      IDX_DEC:  idx_d = idx_m1;
      default:  idx_d = idx_q;
    endcase
    fill_d = fill_q;
    if (cmd_i.fill_inc) begin
      fill_d = fill_q + CW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_m1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      fill_q   <= '0;
      op_q     <= '0;
      hit_q    <= 1'b0;
      status_q <= ST_OK;
    end else begin
      idx_q  <= idx_d;
      fill_q <= fill_d;
      if (cmd_i.capture) begin
        op_q     <= req_cmd_i;
        hit_q    <= 1'b0;
        status_q <= ST_OK;
      end else begin
        if (cmd_i.set_hit) begin
          hit_q <= 1'b1;
        end
        if (cmd_i.set_miss) begin
          status_q <= ST_MISS;
        end else if (cmd_i.set_full) begin
          status_q <= ST_FULL;
        end
      end
    end
  end

  // operand and extremes
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      value_q <= req_value_i;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= ram_rdata;
    end
    if (cmd_i.cap_hi) begin
      hi_q <= ram_rdata;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rsp_hit_q      <= hit_q;
      rsp_status_q   <= status_q;
      rsp_count_q    <= fill_ext[COUNT_W-1:0];
      rsp_smallest_q <= fill_empty ? EMPTY_VALUE : lo_q;
      rsp_largest_q  <= fill_empty ? EMPTY_VALUE : hi_q;
      rsp_empty_q    <= fill_empty;
    end
  end

  // status toward the controller
  always_comb begin
    stat_o.op          = op_q;
    stat_o.full        = (fill_q == CW'(CAPACITY));
    stat_o.idx_zero    = (idx_q == '0);
    stat_o.idx_at_fill = (idx_q == fill_q);
    stat_o.idx_last    = (idx_p1 == fill_q);
    stat_o.rd_gt       = ($signed(ram_rdata) > value_q);
    stat_o.rd_eq       = ($signed(ram_rdata) == value_q);
    stat_o.out_busy    = rsp_valid_q && !rsp_ready_i;
  end

  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_hit_o         = rsp_hit_q;
  assign rsp_status_o      = rsp_status_q;
  assign rsp_entry_count_o = rsp_count_q;
  assign rsp_smallest_o    = rsp_smallest_q;
  assign rsp_largest_o     = rsp_largest_q;
  assign rsp_is_empty_o    = rsp_empty_q;

endmodule

// ----- rtl/core/svt_controller.sv -----
// controller of the sorted value table: sequences scan, shift and result steps
module svt_controller import svt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output svt_cmd_t  cmd_o,
  input  svt_stat_t stat_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CMP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_LO_RD,
    S_HI_RD,
    S_HI_CAP,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{
      capture:  1'b0,
      idx_op:   IDX_HOLD,
      rd_sel:   RD_NONE,
      wr_sel:   WR_NONE,
      fill_inc: 1'b0,
      fill_dec: 1'b0,
      set_hit:  1'b0,
      set_miss: 1'b0,
      set_full: 1'b0,
      cap_lo:   1'b0,
      cap_hi:   1'b0,
      load_out: 1'b0
    };
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.op)
          CMD_INSERT: begin
            if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
              state_d        = S_LO_RD;
            end else begin
              cmd_o.idx_op = IDX_FILL;
              state_d      = S_INS_RD;
            end
          end
          CMD_DELETE, CMD_SEARCH: begin
            cmd_o.idx_op = IDX_ZERO;
            state_d      = S_SCAN_RD;
          end
          default: begin
            state_d = S_LO_RD;
          end
        endcase
      end
      // insert: walk down from the top, moving larger entries up by one
      S_INS_RD: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_sel   = WR_VALUE;
          cmd_o.fill_inc = 1'b1;
          state_d        = S_LO_RD;
        end else begin
          cmd_o.rd_sel = RD_IDX_M1;
          state_d      = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat_i.rd_gt) begin
          cmd_o.wr_sel = WR_RDATA;
          cmd_o.idx_op = IDX_DEC;
          state_d      = S_INS_RD;
        end else begin
          cmd_o.wr_sel   = WR_VALUE;
          cmd_o.fill_inc = 1'b1;
          state_d        = S_LO_RD;
        end
      end
      // delete and search: scan up for the first match or the first larger entry
      S_SCAN_RD: begin
        if (stat_i.idx_at_fill) begin
          cmd_o.set_miss = 1'b1;
          state_d        = S_LO_RD;
        end else begin
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        priority if (stat_i.rd_eq) begin
          cmd_o.set_hit = 1'b1;
          state_d       = (stat_i.op == CMD_DELETE) ? S_DEL_RD : S_LO_RD;
        end else if (stat_i.rd_gt) begin
          cmd_o.set_miss = 1'b1;
          state_d        = S_LO_RD;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_SCAN_RD;
        end
      end
      // delete: close the gap by moving later entries down by one
      S_DEL_RD: begin
        if (stat_i.idx_last) begin
          cmd_o.fill_dec = 1'b1;
          state_d        = S_LO_RD;
        end else begin
          cmd_o.rd_sel = RD_IDX_P1;
          state_d      = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_sel = WR_RDATA;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_DEL_RD;
      end
      // fetch first and last entry for min and max
      S_LO_RD: begin
        cmd_o.rd_sel = RD_FIRST;
        state_d      = S_HI_RD;
      end
      S_HI_RD: begin
        cmd_o.cap_lo = 1'b1;
        cmd_o.rd_sel = RD_LAST;
        state_d      = S_HI_CAP;
      end
      S_HI_CAP: begin
        cmd_o.cap_hi = 1'b1;
        state_d      = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
